[src/charge_port_session_controller_macros.svh]
// ---------------------------------------------------------------------------
// Assertion macros for the charge port session controller
// Each macro expects signals named clk and rst_n in the enclosing module.
// ---------------------------------------------------------------------------
`ifndef CHARGE_PORT_SESSION_CONTROLLER_MACROS_SVH
`define CHARGE_PORT_SESSION_CONTROLLER_MACROS_SVH

// Same-cycle implication, checked outside reset
`define CPSC_ASSERT_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("cpsc same-cycle check failed");

// Next-cycle implication, checked outside reset
`define CPSC_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("cpsc next-cycle check failed");

`endif

[src/cpsc_pkg.sv]
// ---------------------------------------------------------------------------
// cpsc_pkg
// Shared types, codes and reset values of the charge port session controller.
// ---------------------------------------------------------------------------
`default_nettype none

package cpsc_pkg;

  // Operation codes of one input transaction
  typedef enum logic [1:0] {
    OP_TICK  = 2'd0,
    OP_PULSE = 2'd1,
    OP_START = 2'd2,
    OP_STOP  = 2'd3
  } op_t;

  // Result event codes
  typedef enum logic [1:0] {
    EV_NONE    = 2'd0,
    EV_STARTED = 2'd1,
    EV_REPORT  = 2'd2,
    EV_STOPPED = 2'd3
  } evt_t;

  // Stop reason / mark codes
  typedef enum logic [2:0] {
    RSN_NONE      = 3'd0,
    RSN_COMMANDED = 3'd1,
    RSN_CONSUMED  = 3'd2,
    RSN_TIMEOUT   = 3'd3,
    RSN_OVERLOAD  = 3'd4,
    RSN_FULL      = 3'd5
  } reason_t;

  // Configuration register indexes
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 24;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_OVERLOAD_GAP   = 3'd0,
    CFG_OVERLOAD_LIMIT = 3'd1,
    CFG_FULL_GAP       = 3'd2,
    CFG_FULL_LIMIT     = 3'd3,
    CFG_PULSES_PER_COIN = 3'd4,
    CFG_MS_PER_COIN    = 3'd5,
    CFG_REPORT_EVERY   = 3'd6
  } cfg_idx_t;

  // Reset values of the configuration registers
  localparam logic [23:0] RST_OVERLOAD_GAP    = 24'd100;
  localparam logic [7:0]  RST_OVERLOAD_LIMIT  = 8'd10;
  localparam logic [23:0] RST_FULL_GAP        = 24'd60000;
  localparam logic [7:0]  RST_FULL_LIMIT      = 8'd3;
  localparam logic [15:0] RST_PULSES_PER_COIN = 16'd100;
  localparam logic [23:0] RST_MS_PER_COIN     = 24'd3600000;
  localparam logic [7:0]  RST_REPORT_EVERY    = 8'd10;

  // Saturation value of the 8-bit run counters
  localparam logic [7:0] RUN_MAX = 8'hFF;

  // Configuration register file contents
  typedef struct packed {
    logic [23:0] overload_gap_ms;
    logic [7:0]  overload_run_limit;
    logic [23:0] full_gap_ms;
    logic [7:0]  full_run_limit;
    logic [15:0] pulses_per_coin;
    logic [23:0] ms_per_coin;
    logic [7:0]  report_every;
  } cfg_t;

  // One input transaction
  typedef struct packed {
    op_t        op;
    logic       online;
    logic [7:0] coin_qty;
  } item_t;

  // One result transaction
  typedef struct packed {
    evt_t        event_res;
    logic        relay_on;
    logic        session_online;
    logic [31:0] consumed_pulses;
    reason_t     stop_reason;
    logic        final_report;
  } res_t;

endpackage

`default_nettype wire

[src/cpsc_cfg_regs.sv]
// ---------------------------------------------------------------------------
// cpsc_cfg_regs
// Write-only configuration register file; writes beyond the list are dropped.
// ---------------------------------------------------------------------------
`default_nettype none

module cpsc_cfg_regs (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            cfg_we,
  input  wire logic [cpsc_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [cpsc_pkg::CFG_DATA_W-1:0] cfg_wdata,
  output cpsc_pkg::cfg_t                       cfg
);
  import cpsc_pkg::*;

  cfg_t cfg_r;
  cfg_t cfg_nxt;

  // Decode the write
  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      case (cfg_idx_t'(cfg_index))
        CFG_OVERLOAD_GAP:    cfg_nxt.overload_gap_ms    = cfg_wdata;
        CFG_OVERLOAD_LIMIT:  cfg_nxt.overload_run_limit = cfg_wdata[7:0];
        CFG_FULL_GAP:        cfg_nxt.full_gap_ms        = cfg_wdata;
        CFG_FULL_LIMIT:      cfg_nxt.full_run_limit     = cfg_wdata[7:0];
        CFG_PULSES_PER_COIN: cfg_nxt.pulses_per_coin    = cfg_wdata[15:0];
        CFG_MS_PER_COIN:     cfg_nxt.ms_per_coin        = cfg_wdata;
        CFG_REPORT_EVERY:    cfg_nxt.report_every       = cfg_wdata[7:0];
        default:             cfg_nxt = cfg_r;
      endcase
    end
  end

  // Hold the registers, reset to their documented defaults
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.overload_gap_ms    <= RST_OVERLOAD_GAP;
      cfg_r.overload_run_limit <= RST_OVERLOAD_LIMIT;
      cfg_r.full_gap_ms        <= RST_FULL_GAP;
      cfg_r.full_run_limit     <= RST_FULL_LIMIT;
      cfg_r.pulses_per_coin    <= RST_PULSES_PER_COIN;
      cfg_r.ms_per_coin        <= RST_MS_PER_COIN;
      cfg_r.report_every       <= RST_REPORT_EVERY;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

`default_nettype wire

[src/cpsc_in_stage.sv]
// ---------------------------------------------------------------------------
// cpsc_in_stage
// Input register: captures one transaction and holds it until the core takes it.
// ---------------------------------------------------------------------------
`default_nettype none

module cpsc_in_stage (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  output logic            in_stall,
  input  wire logic [1:0] in_operation,
  input  wire logic       in_online,
  input  wire logic [7:0] in_coin_qty,
  input  wire logic       out_ready,
  output logic            item_valid,
  output cpsc_pkg::item_t item
);
  import cpsc_pkg::*;

  logic  valid_r;
  logic  valid_nxt;
  item_t item_r;
  logic  accept;

  // Stall only when a held transaction cannot move on this cycle
  assign in_stall = valid_r && !out_ready;
  assign accept   = in_valid && !in_stall;

  always_comb begin
    if (accept) begin
      valid_nxt = 1'b1;
    end else if (out_ready) begin
      valid_nxt = 1'b0;
    end else begin
      valid_nxt = valid_r;
    end
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  // Payload
  always_ff @(posedge clk) begin
    if (accept) begin
      item_r.op       <= op_t'(in_operation);
      item_r.online   <= in_online;
      item_r.coin_qty <= in_coin_qty;
    end
  end

  assign item_valid = valid_r;
  assign item       = item_r;

endmodule

`default_nettype wire

[src/cpsc_core.sv]
// ---------------------------------------------------------------------------
// cpsc_core
// Session state and the single-pass update for one transaction.
// ---------------------------------------------------------------------------
`default_nettype none

`include "charge_port_session_controller_macros.svh"

module cpsc_core (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire cpsc_pkg::cfg_t  cfg,
  input  wire logic            item_valid,
  input  wire cpsc_pkg::item_t item,
  input  wire logic            out_ready,
  output cpsc_pkg::res_t       res_nxt
);
  import cpsc_pkg::*;

  logic [31:0] now_ms_r,        now_ms_nxt;
  logic [31:0] last_pulse_ms_r, last_pulse_ms_nxt;
  logic [7:0]  short_gap_run_r, short_gap_run_nxt;
  logic [7:0]  long_gap_run_r,  long_gap_run_nxt;
  logic        active_r,        active_nxt;
  logic        is_online_r,     is_online_nxt;
  logic [7:0]  coins_paid_r,    coins_paid_nxt;
  logic [31:0] pulse_total_r,   pulse_total_nxt;
  reason_t     reason_code_r,   reason_code_nxt;
  logic [31:0] time_left_ms_r,  time_left_ms_nxt;
  logic [7:0]  report_run_r,    report_run_nxt;

  logic        adv;
  logic [31:0] gap;
  logic [7:0]  short_inc;
  logic [7:0]  long_inc;
  logic [7:0]  report_inc;
  logic [31:0] pulse_inc;
  logic [23:0] pulse_budget;
  logic [31:0] time_budget;
  evt_t        ev;
  logic        fin;
  logic        idle_pulse;
  logic        stop_adv;

  assign adv = item_valid && out_ready;

  // Shared arithmetic
  assign gap          = now_ms_r - last_pulse_ms_r;
  assign short_inc    = (short_gap_run_r == RUN_MAX) ? RUN_MAX : short_gap_run_r + 8'd1;
  assign long_inc     = (long_gap_run_r == RUN_MAX) ? RUN_MAX : long_gap_run_r + 8'd1;
  assign report_inc   = (report_run_r == RUN_MAX) ? RUN_MAX : report_run_r + 8'd1;
  assign pulse_inc    = pulse_total_r + 32'd1;
  assign pulse_budget = {16'd0, coins_paid_r} * {8'd0, cfg.pulses_per_coin};
  assign time_budget  = {24'd0, item.coin_qty} * {8'd0, cfg.ms_per_coin};

  // Next state for one transaction
  always_comb begin
    now_ms_nxt        = now_ms_r;
    last_pulse_ms_nxt = last_pulse_ms_r;
    short_gap_run_nxt = short_gap_run_r;
    long_gap_run_nxt  = long_gap_run_r;
    active_nxt        = active_r;
    is_online_nxt     = is_online_r;
    coins_paid_nxt    = coins_paid_r;
    pulse_total_nxt   = pulse_total_r;
    reason_code_nxt   = reason_code_r;
    time_left_ms_nxt  = time_left_ms_r;
    report_run_nxt    = report_run_r;
    ev                = EV_NONE;
    fin               = 1'b0;
    case (item.op)
      OP_TICK: begin
        now_ms_nxt = now_ms_r + 32'd1;
        // Count down an offline session, stop on expiry
        if (active_r && !is_online_r) begin
          if (time_left_ms_r <= 32'd1) begin
            time_left_ms_nxt = '0;
            reason_code_nxt  = RSN_TIMEOUT;
            active_nxt       = 1'b0;
            ev               = EV_STOPPED;
            fin              = is_online_r;
          end else begin
            time_left_ms_nxt = time_left_ms_r - 32'd1;
          end
        end
      end
      OP_PULSE: begin
        // Classify the gap and advance the run counters
        if (gap < {8'd0, cfg.overload_gap_ms}) begin
          if (short_inc > cfg.overload_run_limit) begin
            short_gap_run_nxt = '0;
            if (active_r) reason_code_nxt = RSN_OVERLOAD;
          end else begin
            short_gap_run_nxt = short_inc;
          end
        end else if (gap > {8'd0, cfg.full_gap_ms}) begin
          if (long_inc > cfg.full_run_limit) begin
            long_gap_run_nxt = '0;
            if (active_r) reason_code_nxt = RSN_FULL;
          end else begin
            long_gap_run_nxt = long_inc;
          end
        end else begin
          short_gap_run_nxt = '0;
          long_gap_run_nxt  = '0;
        end
        last_pulse_ms_nxt = now_ms_r;
        // Count the pulse within a session
        if (active_r) begin
          pulse_total_nxt = pulse_inc;
          if (!is_online_r) begin
            if (pulse_inc >= {8'd0, pulse_budget}) begin
              reason_code_nxt = RSN_CONSUMED;
              active_nxt      = 1'b0;
              ev              = EV_STOPPED;
              fin             = is_online_r;
            end
          end else if (report_inc >= cfg.report_every) begin
            report_run_nxt = '0;
            ev             = EV_REPORT;
          end else begin
            report_run_nxt = report_inc;
          end
        end
      end
      OP_START: begin
        active_nxt       = 1'b1;
        is_online_nxt    = item.online;
        coins_paid_nxt   = item.coin_qty;
        pulse_total_nxt  = '0;
        reason_code_nxt  = RSN_NONE;
        time_left_ms_nxt = item.online ? 32'd0 : time_budget;
        ev               = EV_STARTED;
      end
      OP_STOP: begin
        if (active_r) begin
          reason_code_nxt = RSN_COMMANDED;
          active_nxt      = 1'b0;
          ev              = EV_STOPPED;
          fin             = is_online_r;
        end
      end
      default: begin
        ev = EV_NONE;
      end
    endcase
  end

  // Build the result from the updated state
  always_comb begin
    res_nxt.event_res       = ev;
    res_nxt.relay_on        = active_nxt;
    res_nxt.session_online  = is_online_nxt;
    res_nxt.consumed_pulses = pulse_total_nxt;
    res_nxt.stop_reason     = reason_code_nxt;
    res_nxt.final_report    = fin;
  end

  // Commit the state when the transaction moves to the output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      now_ms_r        <= '0;
      last_pulse_ms_r <= '0;
      short_gap_run_r <= '0;
      long_gap_run_r  <= '0;
      active_r        <= 1'b0;
      is_online_r     <= 1'b0;
      coins_paid_r    <= '0;
      pulse_total_r   <= '0;
      reason_code_r   <= RSN_NONE;
      time_left_ms_r  <= '0;
      report_run_r    <= '0;
    end else if (adv) begin
      now_ms_r        <= now_ms_nxt;
      last_pulse_ms_r <= last_pulse_ms_nxt;
      short_gap_run_r <= short_gap_run_nxt;
      long_gap_run_r  <= long_gap_run_nxt;
      active_r        <= active_nxt;
      is_online_r     <= is_online_nxt;
      coins_paid_r    <= coins_paid_nxt;
      pulse_total_r   <= pulse_total_nxt;
      reason_code_r   <= reason_code_nxt;
      time_left_ms_r  <= time_left_ms_nxt;
      report_run_r    <= report_run_nxt;
    end
  end

  // Qualifiers for the checks below
  assign idle_pulse = adv && item.op == OP_PULSE && !active_r;
  assign stop_adv   = adv && ev == EV_STOPPED;

  // A start always leaves a running session
  `CPSC_ASSERT_NEXT(a_start_activates, adv && item.op == OP_START, active_r)
  // A pulse outside a session leaves the pulse count alone
  `CPSC_ASSERT_NEXT(a_idle_pulse_uncounted, idle_pulse, pulse_total_r == $past(pulse_total_r))
  // A stop drops the relay and reports only for online sessions
  `CPSC_ASSERT_SAME(a_stop_result, stop_adv, !active_nxt && fin == is_online_r)
  // Periodic reports come only from a running online session
  `CPSC_ASSERT_SAME(a_report_online, adv && ev == EV_REPORT, active_r && is_online_r)

endmodule

`default_nettype wire

[src/cpsc_out_stage.sv]
// ---------------------------------------------------------------------------
// cpsc_out_stage
// Result register: holds one result transaction until the consumer takes it.
// ---------------------------------------------------------------------------
`default_nettype none

module cpsc_out_stage (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           item_valid,
  input  wire cpsc_pkg::res_t res_nxt,
  output logic                out_ready,
  output logic                out_valid,
  input  wire logic           out_stall,
  output logic [1:0]          out_event_res,
  output logic                out_relay_on,
  output logic                out_session_online,
  output logic [31:0]         out_consumed_pulses,
  output logic [2:0]          out_stop_reason,
  output logic                out_final_report
);
  import cpsc_pkg::*;

  logic valid_r;
  logic valid_nxt;
  res_t res_r;
  logic load;

  // Free when empty or being emptied this cycle
  assign out_ready = !valid_r || !out_stall;
  assign load      = item_valid && out_ready;

  always_comb begin
    if (load) begin
      valid_nxt = 1'b1;
    end else if (!out_stall) begin
      valid_nxt = 1'b0;
    end else begin
      valid_nxt = valid_r;
    end
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  // Payload
  always_ff @(posedge clk) begin
    if (load) begin
      res_r <= res_nxt;
    end
  end

  assign out_valid           = valid_r;
  assign out_event_res       = res_r.event_res;
  assign out_relay_on        = res_r.relay_on;
  assign out_session_online  = res_r.session_online;
  assign out_consumed_pulses = res_r.consumed_pulses;
  assign out_stop_reason     = res_r.stop_reason;
  assign out_final_report    = res_r.final_report;

endmodule

`default_nettype wire

[src/charge_port_session_controller.sv]
// ---------------------------------------------------------------------------
// charge_port_session_controller
// Relay and session control for one charging port: ticks, meter pulses,
// start and stop commands in; one status result out per transaction.
// ---------------------------------------------------------------------------
//
//   Channel  Direction  Handshake            Payload
//   in       sink       in_valid / in_stall  in_operation, in_online, in_coin_qty
//   out      source     out_valid/out_stall  out_event_res .. out_final_report
//   cfg      sink       cfg_we               cfg_index, cfg_wdata
//
// One transaction per cycle sustained while out is not stalled. out_valid rises
// once a transaction has passed the input register and then one update pass
// into the result register. The rate is set by the single update pass of the
// session state.
// rst_n is synchronous; it clears session state and loads register defaults.
// A stall on out holds the result and back-pressures in after one held item.
// ---------------------------------------------------------------------------
`default_nettype none

module charge_port_session_controller (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            in_valid,
  output logic                                 in_stall,
  input  wire logic [1:0]                      in_operation,
  input  wire logic                            in_online,
  input  wire logic [7:0]                      in_coin_qty,
  output logic                                 out_valid,
  input  wire logic                            out_stall,
  output logic [1:0]                           out_event_res,
  output logic                                 out_relay_on,
  output logic                                 out_session_online,
  output logic [31:0]                          out_consumed_pulses,
  output logic [2:0]                           out_stop_reason,
  output logic                                 out_final_report,
  input  wire logic                            cfg_we,
  input  wire logic [cpsc_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [cpsc_pkg::CFG_DATA_W-1:0] cfg_wdata
);
  import cpsc_pkg::*;

  cfg_t  cfg;
  item_t item;
  logic  item_valid;
  logic  out_ready;
  res_t  res_nxt;

  // Configuration registers
  cpsc_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  // Input register
  cpsc_in_stage u_in (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_operation (in_operation),
    .in_online    (in_online),
    .in_coin_qty  (in_coin_qty),
    .out_ready    (out_ready),
    .item_valid   (item_valid),
    .item         (item)
  );

  // Session state and update
  cpsc_core u_core (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg),
    .item_valid (item_valid),
    .item       (item),
    .out_ready  (out_ready),
    .res_nxt    (res_nxt)
  );

  // Result register
  cpsc_out_stage u_out (
    .clk                 (clk),
    .rst_n               (rst_n),
    .item_valid          (item_valid),
    .res_nxt             (res_nxt),
    .out_ready           (out_ready),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_event_res       (out_event_res),
    .out_relay_on        (out_relay_on),
    .out_session_online  (out_session_online),
    .out_consumed_pulses (out_consumed_pulses),
    .out_stop_reason     (out_stop_reason),
    .out_final_report    (out_final_report)
  );

endmodule

`default_nettype wire

[dv/charge_port_session_controller_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// charge_port_session_controller_tb
// Self-checking bench for the charge port session controller. Ticks, meter
// pulses, start and stop transactions go in on a valid/stall channel with
// random gaps. A transaction-level model of the session state predicts every status
// transaction, and each result taken from the block is compared field by field
// with the oldest prediction. Settings are reloaded between phases while idle.
// ----------------------------------------------------------------------------

module charge_port_session_controller_tb;

  import cpsc_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 200000;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  logic [1:0]  in_operation;
  logic        in_online;
  logic [7:0]  in_coin_qty;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [1:0]  out_event_res;
  logic        out_relay_on;
  logic        out_session_online;
  logic [31:0] out_consumed_pulses;
  logic [2:0]  out_stop_reason;
  logic        out_final_report;
  logic        cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  // Shadow of the register file and of the session state
  cfg_t        settings;
  logic [31:0] clock_ms;
  logic [31:0] prev_pulse_at;
  logic [31:0] pulse_count;
  logic [31:0] ms_budget;
  logic [7:0]  short_run;
  logic [7:0]  long_run;
  logic [7:0]  coins_held;
  logic [7:0]  report_gap_cnt;
  logic        relay;
  logic        card;
  reason_t     reason_mark;

  res_t        status_due[$];
  res_t        want_status;
  item_t       taken;
  int unsigned mismatch_count = 0;
  int unsigned results_seen   = 0;
  int unsigned items_sent     = 0;
  int unsigned cycle_count    = 0;
  int unsigned hold_left      = 0;
  logic        in_quiet       = 1'b0;
  logic        out_quiet      = 1'b0;

  charge_port_session_controller dut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_stall            (in_stall),
    .in_operation        (in_operation),
    .in_online           (in_online),
    .in_coin_qty         (in_coin_qty),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_event_res       (out_event_res),
    .out_relay_on        (out_relay_on),
    .out_session_online  (out_session_online),
    .out_consumed_pulses (out_consumed_pulses),
    .out_stop_reason     (out_stop_reason),
    .out_final_report    (out_final_report),
    .cfg_we              (cfg_we),
    .cfg_index           (cfg_index),
    .cfg_wdata           (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // ------------------------------------------------------------------------
  // Session model
  // ------------------------------------------------------------------------

  function automatic res_t port_status(input evt_t ev, input logic fin);
    res_t r;
    r.event_res       = ev;
    r.relay_on        = relay;
    r.session_online  = card;
    r.consumed_pulses = pulse_count;
    r.stop_reason     = reason_mark;
    r.final_report    = fin;
    return r;
  endfunction

  function automatic res_t close_session(input reason_t why);
    reason_mark = why;
    relay       = 1'b0;
    return port_status(EV_STOPPED, card);
  endfunction

  // Advance the shadow state by one transaction and return its status
  function automatic res_t session_step(input item_t it);
    logic [31:0] gap_ms;
    logic [31:0] pulse_budget;
    case (it.op)
      OP_TICK: begin
        clock_ms = clock_ms + 32'd1;
        if (relay && !card) begin
          if (ms_budget <= 32'd1) begin
            ms_budget = 32'd0;
            return close_session(RSN_TIMEOUT);
          end
          ms_budget = ms_budget - 32'd1;
        end
        return port_status(EV_NONE, 1'b0);
      end
      OP_PULSE: begin
        // classify the gap since the previous pulse, wrapping with the clock
        gap_ms = clock_ms - prev_pulse_at;
        if (gap_ms < {8'd0, settings.overload_gap_ms}) begin
          if (short_run != RUN_MAX) short_run = short_run + 8'd1;
          if (short_run > settings.overload_run_limit) begin
            short_run = 8'd0;
            if (relay) reason_mark = RSN_OVERLOAD;
          end
        end else if (gap_ms > {8'd0, settings.full_gap_ms}) begin
          if (long_run != RUN_MAX) long_run = long_run + 8'd1;
          if (long_run > settings.full_run_limit) begin
            long_run = 8'd0;
            if (relay) reason_mark = RSN_FULL;
          end
        end else begin
          short_run = 8'd0;
          long_run  = 8'd0;
        end
        prev_pulse_at = clock_ms;
        if (!relay) return port_status(EV_NONE, 1'b0);
        pulse_count = pulse_count + 32'd1;
        if (!card) begin
          pulse_budget = coins_held * settings.pulses_per_coin;
          if (pulse_count >= pulse_budget) return close_session(RSN_CONSUMED);
          return port_status(EV_NONE, 1'b0);
        end
        if (report_gap_cnt != RUN_MAX) report_gap_cnt = report_gap_cnt + 8'd1;
        if (report_gap_cnt >= settings.report_every) begin
          report_gap_cnt = 8'd0;
          return port_status(EV_REPORT, 1'b0);
        end
        return port_status(EV_NONE, 1'b0);
      end
      OP_START: begin
        // a running session is dropped silently
        relay       = 1'b1;
        card        = it.online;
        coins_held  = it.coin_qty;
        pulse_count = 32'd0;
        reason_mark = RSN_NONE;
        ms_budget   = card ? 32'd0 : coins_held * settings.ms_per_coin;
        return port_status(EV_STARTED, 1'b0);
      end
      default: begin
        if (!relay) return port_status(EV_NONE, 1'b0);
        return close_session(RSN_COMMANDED);
      end
    endcase
  endfunction

  // ------------------------------------------------------------------------
  // Monitors and checking
  // ------------------------------------------------------------------------

  task automatic report_mismatch(input string what);
    $display("%0t ns  %s", $time, what);
    mismatch_count++;
  endtask

  task automatic check_field(input string name, input logic [31:0] got,
                             input logic [31:0] want);
    if (got !== want)
      report_mismatch($sformatf("result %0d: %s is %0h, expected %0h",
                                results_seen, name, got, want));
  endtask

  // Predict each transaction the block takes in
  always @(posedge clk) begin : predict_on_accept
    if (rst_n && in_valid && in_stall === 1'b0) begin
      taken.op       = op_t'(in_operation);
      taken.online   = in_online;
      taken.coin_qty = in_coin_qty;
      status_due.push_back(session_step(taken));
    end
  end

  // Compare each status transaction with the oldest prediction
  always @(posedge clk) begin : check_results
    if (rst_n && out_valid === 1'b1 && !out_stall) begin
      results_seen++;
      if (status_due.size() == 0) begin
        report_mismatch($sformatf("result %0d arrived with nothing outstanding",
                                  results_seen));
      end else begin
        want_status = status_due.pop_front();
        check_field("event_res", 32'(out_event_res), 32'(want_status.event_res));
        check_field("relay_on", 32'(out_relay_on), 32'(want_status.relay_on));
        check_field("session_online", 32'(out_session_online),
                    32'(want_status.session_online));
        check_field("consumed_pulses", out_consumed_pulses,
                    want_status.consumed_pulses);
        check_field("stop_reason", 32'(out_stop_reason),
                    32'(want_status.stop_reason));
        check_field("final_report", 32'(out_final_report),
                    32'(want_status.final_report));
      end
    end
  end

  // Hold off the result channel for a random count after each transaction
  always @(posedge clk) begin : drive_out_stall
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left = hold_left - 1;
      out_stall <= (hold_left != 0);
    end else if (out_valid === 1'b1 && !out_stall) begin
      if ($urandom_range(0, 39) == 0) out_quiet = !out_quiet;
      hold_left = out_quiet ? 0 : $urandom_range(0, 15);
      out_stall <= (hold_left != 0);
    end
  end

  // Bound the run
  always @(posedge clk) begin : watchdog
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("charge_port_session_controller_tb: done, errors");
      $finish;
    end
  end

  // ------------------------------------------------------------------------
  // Stimulus helpers
  // ------------------------------------------------------------------------

  // Offer one transaction after a random pause; return once it is taken
  task automatic send_item(input op_t op, input logic online, input logic [7:0] coins);
    int unsigned pause;
    if (items_sent % 40 == 0) in_quiet = ($urandom_range(0, 2) == 0);
    pause = in_quiet ? 0 : $urandom_range(0, 15);
    if (pause != 0) begin
      in_valid <= 1'b0;
      repeat (pause) @(posedge clk);
    end
    in_valid     <= 1'b1;
    in_operation <= op;
    in_online    <= online;
    in_coin_qty  <= coins;
    do @(posedge clk); while (in_stall !== 1'b0);
    items_sent++;
  endtask

  // Drop valid and wait until every predicted status has come back
  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (status_due.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Write all seven registers; junk in the unused upper data bits
  task automatic load_settings(input cfg_t c);
    logic [23:0] junk;
    junk = 24'($urandom);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_OVERLOAD_GAP;
    cfg_wdata <= c.overload_gap_ms;
    @(posedge clk);
    cfg_index <= CFG_OVERLOAD_LIMIT;
    cfg_wdata <= {junk[23:8], c.overload_run_limit};
    @(posedge clk);
    cfg_index <= CFG_FULL_GAP;
    cfg_wdata <= c.full_gap_ms;
    @(posedge clk);
    cfg_index <= CFG_FULL_LIMIT;
    cfg_wdata <= {junk[15:0], c.full_run_limit};
    @(posedge clk);
    cfg_index <= CFG_PULSES_PER_COIN;
    cfg_wdata <= {junk[7:0], c.pulses_per_coin};
    @(posedge clk);
    cfg_index <= CFG_MS_PER_COIN;
    cfg_wdata <= c.ms_per_coin;
    @(posedge clk);
    cfg_index <= CFG_REPORT_EVERY;
    cfg_wdata <= {junk[23:8], c.report_every};
    @(posedge clk);
    cfg_we   <= 1'b0;
    settings  = c;
  endtask

  function automatic cfg_t make_settings(input logic [23:0] ovl_gap, input logic [7:0] ovl_lim,
                                         input logic [23:0] full_gap, input logic [7:0] full_lim,
                                         input logic [15:0] ppc, input logic [23:0] mpc,
                                         input logic [7:0] every);
    cfg_t c;
    c.overload_gap_ms    = ovl_gap;
    c.overload_run_limit = ovl_lim;
    c.full_gap_ms        = full_gap;
    c.full_run_limit     = full_lim;
    c.pulses_per_coin    = ppc;
    c.ms_per_coin        = mpc;
    c.report_every       = every;
    return c;
  endfunction

  // Small thresholds and budgets so every class and stop cause turns up
  function automatic cfg_t random_settings();
    logic [23:0] ovl_gap;
    ovl_gap = 24'($urandom_range(0, 4));
    return make_settings(ovl_gap, 8'($urandom_range(0, 4)),
                         ovl_gap + 24'($urandom_range(0, 8)),
                         8'($urandom_range(0, 3)), 16'($urandom_range(0, 6)),
                         24'($urandom_range(0, 40)), 8'($urandom_range(1, 6)));
  endfunction

  function automatic logic [7:0] pick_coins();
    logic [7:0] c;
    case ($urandom_range(0, 7))
      0:       c = 8'd0;
      7:       c = 8'($urandom_range(0, 255));
      default: c = 8'($urandom_range(1, 3));
    endcase
    return c;
  endfunction

  // Mostly whole sessions with random content, with some noise between them
  task automatic random_sessions(input int unsigned quota, input int unsigned tick_span);
    int unsigned first;
    int unsigned steps;
    int unsigned roll;
    first = items_sent;
    while (items_sent - first < quota) begin
      if ($urandom_range(0, 7) == 0) begin
        send_item(op_t'($urandom_range(0, 3)), 1'($urandom_range(0, 1)),
                  8'($urandom_range(0, 255)));
      end else begin
        send_item(OP_START, 1'($urandom_range(0, 1)), pick_coins());
        steps = $urandom_range(1, 20);
        repeat (steps) begin
          roll = $urandom_range(0, 19);
          if (roll < 9) begin
            repeat ($urandom_range(1, tick_span))
              send_item(OP_TICK, 1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)));
          end else if (roll < 18) begin
            send_item(OP_PULSE, 1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)));
          end else if (roll == 18) begin
            send_item(OP_STOP, 1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)));
          end else begin
            send_item(OP_START, 1'($urandom_range(0, 1)), pick_coins());
          end
        end
        if ($urandom_range(0, 3) != 0)
          send_item(OP_STOP, 1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)));
      end
    end
  endtask

  // ------------------------------------------------------------------------
  // Tests
  // ------------------------------------------------------------------------

  // Reset values of the registers, before any write
  task automatic test_reset_defaults();
    send_item(OP_STOP, 1'b1, 8'hFF);
    send_item(OP_START, 1'b0, 8'd255);
    send_item(OP_PULSE, 1'b1, 8'h00);
    send_item(OP_TICK, 1'b0, 8'hAA);
    send_item(OP_STOP, 1'b0, 8'h00);
  endtask

  // Gap classes, marks, zero budgets, restart and report on every pulse
  task automatic test_special_cases();
    settle();
    load_settings(make_settings(24'd1, 8'd0, 24'd1, 8'd0, 16'd2, 24'd2, 8'd0));
    // idle pulses move only the gap tracking
    send_item(OP_PULSE, 1'b0, 8'h00);
    send_item(OP_PULSE, 1'b1, 8'hFF);
    send_item(OP_START, 1'b1, 8'h5A);
    // short gap marks overload, then two ticks give a long gap that marks full
    send_item(OP_PULSE, 1'b0, 8'h00);
    send_item(OP_TICK, 1'b0, 8'h00);
    send_item(OP_TICK, 1'b1, 8'hFF);
    send_item(OP_PULSE, 1'b0, 8'h00);
    send_item(OP_STOP, 1'b0, 8'h00);
    send_item(OP_TICK, 1'b0, 8'h00);
    // zero time budget, then zero pulse budget
    send_item(OP_START, 1'b0, 8'd0);
    send_item(OP_TICK, 1'b0, 8'd0);
    send_item(OP_START, 1'b0, 8'd0);
    send_item(OP_PULSE, 1'b0, 8'd0);
    // restart while running, then the consuming pulse also marks overload
    send_item(OP_START, 1'b0, 8'd1);
    send_item(OP_START, 1'b0, 8'd1);
    send_item(OP_PULSE, 1'b0, 8'd0);
    send_item(OP_PULSE, 1'b0, 8'd0);
    // time budget runs out
    send_item(OP_START, 1'b0, 8'd1);
    send_item(OP_TICK, 1'b0, 8'd0);
    send_item(OP_TICK, 1'b0, 8'd0);
    send_item(OP_START, 1'b1, 8'd1);
    send_item(OP_STOP, 1'b1, 8'd1);
  endtask

  task automatic test_random_traffic();
    settle();
    load_settings(random_settings());
    random_sessions(60, 6);
    settle();
    load_settings(random_settings());
    random_sessions(60, 6);
  endtask

  // Every register at its lowest, but report_every at one
  task automatic test_zero_settings();
    settle();
    load_settings(make_settings(24'd0, 8'd0, 24'd0, 8'd0, 16'd0, 24'd0, 8'd1));
    random_sessions(40, 2);
  endtask

  // Every register at its highest: the short-gap run counter saturates and the report count wraps at its limit
  task automatic test_run_saturation();
    settle();
    load_settings(make_settings(24'hFFFFFF, 8'hFF, 24'hFFFFFF, 8'hFF, 16'hFFFF,
                                24'hFFFFFF, 8'hFF));
    send_item(OP_START, 1'b1, 8'hFF);
    repeat (270) send_item(OP_PULSE, 1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)));
    send_item(OP_STOP, 1'b0, 8'h00);
    random_sessions(20, 3);
  endtask

  // Sender waits for every outstanding status halfway through
  task automatic test_paused_traffic();
    settle();
    load_settings(random_settings());
    random_sessions(40, 6);
    settle();
    random_sessions(40, 6);
  endtask

  initial begin
    in_valid     = 1'b0;
    in_operation = OP_TICK;
    in_online    = 1'b0;
    in_coin_qty  = 8'd0;
    cfg_we       = 1'b0;
    cfg_index    = CFG_OVERLOAD_GAP;
    cfg_wdata    = '0;
    rst_n        = 1'b0;

    // shadow state as it stands after reset
    settings = make_settings(RST_OVERLOAD_GAP, RST_OVERLOAD_LIMIT, RST_FULL_GAP,
                             RST_FULL_LIMIT, RST_PULSES_PER_COIN, RST_MS_PER_COIN,
                             RST_REPORT_EVERY);
    clock_ms       = '0;
    prev_pulse_at  = '0;
    pulse_count    = '0;
    ms_budget      = '0;
    short_run      = '0;
    long_run       = '0;
    coins_held     = '0;
    report_gap_cnt = '0;
    relay          = 1'b0;
    card           = 1'b0;
    reason_mark    = RSN_NONE;

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    test_reset_defaults();
    test_special_cases();
    test_random_traffic();
    test_zero_settings();
    test_run_saturation();
    test_paused_traffic();

    settle();
    if (mismatch_count == 0) begin
      $display("charge_port_session_controller_tb: done, clean");
    end else begin
      $display("charge_port_session_controller_tb: done, errors");
    end
    $finish;
  end

endmodule
